// ----- rtl/lprip_pkg.sv -----
// ----------------------------------------------------------------------------
// Lidar range image projection package
// Shared widths, constants, the arctangent table and the structs that travel
// down the cell chains.
// ----------------------------------------------------------------------------
package lprip_pkg;

    // Field and datapath widths.
    localparam int COORD_W      = 24;
    localparam int DIFF_W       = 25;
    localparam int SQ_W         = 49;
    localparam int RAD_W        = 64;
    localparam int ROOT_STEPS   = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 58;
    localparam int ANGLE_W      = 32;
    localparam int COL_W        = 11;
    localparam int ROW_W        = 11;
    localparam int RANGE_W      = 25;
    localparam int CFG_IDX_W    = 2;

    // Parameter defaults.
    localparam int IMAGE_COLUMNS_DEF = 2048;
    localparam int IMAGE_ROWS_DEF    = 1024;

    // Saturation limit of the range output.
    localparam logic [RANGE_W-1:0] RANGE_MAX = 25'd29058990;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 2'd2;

    // Angles in units of 2^-32 of a full turn.
    localparam logic [ANGLE_W-1:0] QUARTER_TURN       = 32'h4000_0000;
    localparam logic [ANGLE_W-1:0] HALF_TURN          = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

    // Arctangent of 2^-i, rounded, in turn units.
    function automatic logic [ANGLE_W-1:0] atan_entry(input int unsigned idx);
        logic [ANGLE_W-1:0] val;
        case (idx)
            0:       val = 32'd536870912;
            1:       val = 32'd316933406;
            2:       val = 32'd167458907;
            3:       val = 32'd85004756;
            4:       val = 32'd42667331;
            5:       val = 32'd21354465;
            6:       val = 32'd10679838;
            7:       val = 32'd5340245;
            8:       val = 32'd2670163;
            9:       val = 32'd1335087;
            10:      val = 32'd667544;
            11:      val = 32'd333772;
            12:      val = 32'd166886;
            13:      val = 32'd83443;
            14:      val = 32'd41722;
            15:      val = 32'd20861;
            16:      val = 32'd10430;
            17:      val = 32'd5215;
            18:      val = 32'd2608;
            19:      val = 32'd1304;
            20:      val = 32'd652;
            21:      val = 32'd326;
            22:      val = 32'd163;
            23:      val = 32'd81;
            24:      val = 32'd41;
            25:      val = 32'd20;
            26:      val = 32'd10;
            27:      val = 32'd5;
            28:      val = 32'd3;
            29:      val = 32'd1;
            default: val = '0;
        endcase
        return val;
    endfunction

    // Translated point carried beside the square root chain.
    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        logic                     zero;
    } side_t;

    // Two square root lanes: a gives the range, b the horizontal distance.
    typedef struct packed {
        logic [RAD_W-1:0] n_a;
        logic [RAD_W-1:0] r_a;
        logic [RAD_W-1:0] n_b;
        logic [RAD_W-1:0] r_b;
    } root_t;

    // Two rotation lanes: a gives the azimuth, e the elevation.
    typedef struct packed {
        logic signed [CORDIC_W-1:0] u_a;
        logic signed [CORDIC_W-1:0] v_a;
        logic [ANGLE_W-1:0]         acc_a;
        logic signed [CORDIC_W-1:0] u_e;
        logic signed [CORDIC_W-1:0] v_e;
        logic [ANGLE_W-1:0]         acc_e;
    } rot_t;

    // Range and zero flag carried beside the rotation chain.
    typedef struct packed {
        logic [RANGE_W-1:0] rng;
        logic               zero;
    } meta_t;

endpackage

// ----- rtl/lprip_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// Square root cell
// One digit step of a restoring integer square root on two lanes, with the
// translated point passed along beside them.
// ----------------------------------------------------------------------------
module lprip_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  lprip_pkg::root_t  root_in,
    input  lprip_pkg::side_t  side_in,
    output logic              valid_out,
    output lprip_pkg::root_t  root_out,
    output lprip_pkg::side_t  side_out
);

    localparam logic [lprip_pkg::RAD_W-1:0] BIT_K =
        lprip_pkg::RAD_W'(64'd1 << (62 - 2 * STEP));

    logic                    valid_reg;
    lprip_pkg::root_t        root_reg;
    lprip_pkg::root_t        root_next;
    lprip_pkg::side_t        side_reg;
    logic [lprip_pkg::RAD_W:0] trial_a;
    logic [lprip_pkg::RAD_W:0] trial_b;
    logic                    take_a;
    logic                    take_b;

    // Trial subtraction for each lane.
    always_comb
    begin
        trial_a = {1'b0, root_in.r_a} + {1'b0, BIT_K};
        trial_b = {1'b0, root_in.r_b} + {1'b0, BIT_K};
        take_a  = {1'b0, root_in.n_a} >= trial_a;
        take_b  = {1'b0, root_in.n_b} >= trial_b;
        root_next.n_a = take_a ? root_in.n_a - trial_a[lprip_pkg::RAD_W-1:0] : root_in.n_a;
        root_next.r_a = take_a ? (root_in.r_a >> 1) + BIT_K : root_in.r_a >> 1;
        root_next.n_b = take_b ? root_in.n_b - trial_b[lprip_pkg::RAD_W-1:0] : root_in.n_b;
        root_next.r_b = take_b ? (root_in.r_b >> 1) + BIT_K : root_in.r_b >> 1;
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;

endmodule

// ----- rtl/lprip_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// Vectoring rotation cell
// One CORDIC vectoring step on the azimuth and elevation lanes. A lane whose
// second component is zero is finished and passes unchanged.
// ----------------------------------------------------------------------------
module lprip_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  lprip_pkg::rot_t   rot_in,
    input  lprip_pkg::meta_t  meta_in,
    output logic              valid_out,
    output lprip_pkg::rot_t   rot_out,
    output lprip_pkg::meta_t  meta_out
);

    localparam logic [lprip_pkg::ANGLE_W-1:0] ATAN_K = lprip_pkg::atan_entry(STEP);

    logic             valid_reg;
    lprip_pkg::rot_t  rot_reg;
    lprip_pkg::rot_t  rot_next;
    lprip_pkg::meta_t meta_reg;
    logic signed [lprip_pkg::CORDIC_W-1:0] du_a;
    logic signed [lprip_pkg::CORDIC_W-1:0] dv_a;
    logic signed [lprip_pkg::CORDIC_W-1:0] du_e;
    logic signed [lprip_pkg::CORDIC_W-1:0] dv_e;

    // Rotate each lane toward the positive first axis.
    always_comb
    begin
        du_a = rot_in.v_a >>> STEP;
        dv_a = rot_in.u_a >>> STEP;
        du_e = rot_in.v_e >>> STEP;
        dv_e = rot_in.u_e >>> STEP;
        rot_next = rot_in;
        if (rot_in.v_a != '0)
        begin
            if (!rot_in.v_a[lprip_pkg::CORDIC_W-1])
            begin
                rot_next.u_a   = rot_in.u_a + du_a;
                rot_next.v_a   = rot_in.v_a - dv_a;
                rot_next.acc_a = rot_in.acc_a + ATAN_K;
            end
            else
            begin
                rot_next.u_a   = rot_in.u_a - du_a;
                rot_next.v_a   = rot_in.v_a + dv_a;
                rot_next.acc_a = rot_in.acc_a - ATAN_K;
            end
        end
        if (rot_in.v_e != '0)
        begin
            if (!rot_in.v_e[lprip_pkg::CORDIC_W-1])
            begin
                rot_next.u_e   = rot_in.u_e + du_e;
                rot_next.v_e   = rot_in.v_e - dv_e;
                rot_next.acc_e = rot_in.acc_e + ATAN_K;
            end
            else
            begin
                rot_next.u_e   = rot_in.u_e - du_e;
                rot_next.v_e   = rot_in.v_e + dv_e;
                rot_next.acc_e = rot_in.acc_e - ATAN_K;
            end
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg  <= rot_next;
            meta_reg <= meta_in;
        end
    end

    assign valid_out = valid_reg;
    assign rot_out   = rot_reg;
    assign meta_out  = meta_reg;

endmodule

// ----- rtl/lprip_map.sv -----
// ----------------------------------------------------------------------------
// Pixel mapping stages
// Turns azimuth and elevation angles into a column and a row, over five
// registered stages; the last stage is the output register.
// ----------------------------------------------------------------------------
module lprip_map #(
    parameter int IMAGE_COLUMNS = lprip_pkg::IMAGE_COLUMNS_DEF,
    parameter int IMAGE_ROWS    = lprip_pkg::IMAGE_ROWS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            valid_in,
    input  logic [lprip_pkg::ANGLE_W-1:0]   yaw,
    input  logic [lprip_pkg::ANGLE_W-1:0]   elev,
    input  lprip_pkg::meta_t                meta_in,
    output logic                            valid_out,
    output logic [lprip_pkg::COL_W-1:0]     pixel_column,
    output logic [lprip_pkg::ROW_W-1:0]     pixel_row,
    output logic [lprip_pkg::RANGE_W-1:0]   range_value,
    output logic                            zero_range
);

    localparam logic [13:0] COLS_K  = 14'(IMAGE_COLUMNS);
    localparam logic [13:0] ROWS_K  = 14'(IMAGE_ROWS);
    localparam logic [20:0] RECIP_K = 21'((64'd1 << 28) / 180);
    localparam logic signed [29:0] PITCH_OFS = 30'sd93323264;   // 89 degrees
    localparam logic signed [29:0] PITCH_HALF = 30'sd188743680; // 180 degrees

    logic [4:0]  valid_reg;
    logic [45:0] col_prod;
    logic [40:0] ep_next;
    logic [40:0] ep_reg;
    logic [40:0] ep_shift;
    logic signed [29:0] p_raw;
    logic signed [29:0] p_wrap;
    logic signed [29:0] p_fold;
    logic [27:0] p_reg;
    logic [40:0] num_next;
    logic [40:0] num_reg;
    logic [41:0] qa_prod;
    logic [20:0] q0_reg;
    logic [13:0] qa_reg;
    logic        lowz_reg;
    logic [21:0] qa_times;
    logic [21:0] rem;
    logic [13:0] qa_fix;
    logic [21:0] rem_fix;
    logic [13:0] quot;
    logic [13:0] row_full;
    logic [lprip_pkg::COL_W-1:0]   col_reg [0:3];
    logic [lprip_pkg::RANGE_W-1:0] rng_reg [0:3];
    logic [3:0]                    zero_reg;
    logic [lprip_pkg::COL_W-1:0]   col_out_reg;
    logic [lprip_pkg::ROW_W-1:0]   row_out_reg;
    logic [lprip_pkg::RANGE_W-1:0] rng_out_reg;
    logic                          zero_out_reg;

    // Column product and pitch scaling.
    always_comb
    begin
        col_prod = yaw * COLS_K;
        ep_next  = $signed({{9{elev[lprip_pkg::ANGLE_W-1]}}, elev}) * 41'sd360;
    end

    // Pitch offset and wrap into half a turn.
    always_comb
    begin
        ep_shift = $signed(ep_reg) >>> 12;
        p_raw    = $signed(ep_shift[29:0]) + PITCH_OFS;
        p_wrap   = p_raw[29] ? p_raw + PITCH_HALF : p_raw;
        p_fold   = (p_wrap >= PITCH_HALF) ? p_wrap - PITCH_HALF : p_wrap;
        num_next = p_reg * ROWS_K;
        qa_prod  = num_reg[40:20] * RECIP_K;
    end

    // Quotient correction and rounding up.
    always_comb
    begin
        qa_times = qa_reg * 8'd180;
        rem      = {1'b0, q0_reg} - qa_times;
        if (rem >= 22'd180)
        begin
            qa_fix  = qa_reg + 14'd1;
            rem_fix = rem - 22'd180;
        end
        else
        begin
            qa_fix  = qa_reg;
            rem_fix = rem;
        end
        quot     = qa_fix + {13'd0, (rem_fix != '0) || lowz_reg};
        row_full = ROWS_K - quot;
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], valid_in};
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg[0]  <= col_prod[42:32];
            ep_reg      <= ep_next;
            rng_reg[0]  <= meta_in.rng;
            zero_reg[0] <= meta_in.zero;

            p_reg       <= p_fold[27:0];
            col_reg[1]  <= col_reg[0];
            rng_reg[1]  <= rng_reg[0];
            zero_reg[1] <= zero_reg[0];

            num_reg     <= num_next;
            col_reg[2]  <= col_reg[1];
            rng_reg[2]  <= rng_reg[1];
            zero_reg[2] <= zero_reg[1];

            q0_reg      <= num_reg[40:20];
            qa_reg      <= qa_prod[41:28];
            lowz_reg    <= num_reg[19:0] != '0;
            col_reg[3]  <= col_reg[2];
            rng_reg[3]  <= rng_reg[2];
            zero_reg[3] <= zero_reg[2];

            col_out_reg  <= zero_reg[3] ? '0 : col_reg[3];
            row_out_reg  <= zero_reg[3] ? '0 : row_full[lprip_pkg::ROW_W-1:0];
            rng_out_reg  <= zero_reg[3] ? '0 : rng_reg[3];
            zero_out_reg <= zero_reg[3];
        end
    end

    assign valid_out    = valid_reg[4];
    assign pixel_column = col_out_reg;
    assign pixel_row    = row_out_reg;
    assign range_value  = rng_out_reg;
    assign zero_range   = zero_out_reg;

endmodule

// ----- rtl/lidar_point_range_image_projection.sv -----
// ----------------------------------------------------------------------------
// Lidar point range image projection
// Translates each lidar point by the vehicle origin and maps it to a
// panorama pixel, with its range.
// ----------------------------------------------------------------------------
// The block takes one point per clock cycle while the chain is not stalled
// and returns one result per point. The path is a chain of cells: three
// front stages (translate, square, sum), 32 square root cells that each
// settle one root bit, one setup stage, 30 CORDIC cells that each apply one
// arctangent step to the azimuth and elevation vectors at once, and five
// mapping stages ending in the output register. A stalled result holds the
// whole chain, so in_stall follows out_stall while a result is waiting.
// Points whose translated coordinates are all zero give zero_range set and
// zero in the other fields.
module lidar_point_range_image_projection #(
    parameter int IMAGE_COLUMNS = lprip_pkg::IMAGE_COLUMNS_DEF,
    parameter int IMAGE_ROWS    = lprip_pkg::IMAGE_ROWS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [lprip_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lprip_pkg::COORD_W-1:0]          cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [lprip_pkg::COORD_W-1:0]   point_x,
    input  logic signed [lprip_pkg::COORD_W-1:0]   point_y,
    input  logic signed [lprip_pkg::COORD_W-1:0]   point_z,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [lprip_pkg::COL_W-1:0]            pixel_column,
    output logic [lprip_pkg::ROW_W-1:0]            pixel_row,
    output logic [lprip_pkg::RANGE_W-1:0]          range_value,
    output logic                                   zero_range
);

    localparam int NR = lprip_pkg::ROOT_STEPS;
    localparam int NC = lprip_pkg::CORDIC_STEPS;
    localparam int DW = lprip_pkg::DIFF_W;
    localparam int CW = lprip_pkg::CORDIC_W;

    logic en;

    logic signed [lprip_pkg::COORD_W-1:0] origin_x_reg;
    logic signed [lprip_pkg::COORD_W-1:0] origin_y_reg;
    logic signed [lprip_pkg::COORD_W-1:0] origin_z_reg;

    // Front stages.
    logic [2:0]            front_valid_reg;
    lprip_pkg::side_t      diff_next;
    lprip_pkg::side_t      diff_reg;
    lprip_pkg::side_t      sq_side_reg;
    logic [lprip_pkg::SQ_W-1:0] sqx_reg;
    logic [lprip_pkg::SQ_W-1:0] sqy_reg;
    logic [lprip_pkg::SQ_W-1:0] sqz_reg;
    logic [lprip_pkg::SQ_W:0]   hsq;
    logic [lprip_pkg::SQ_W:0]   rsq;
    lprip_pkg::root_t      root_start;
    lprip_pkg::root_t      root_start_reg;
    lprip_pkg::side_t      side_start_reg;

    // Chains.
    logic                  root_valid [0:NR];
    lprip_pkg::root_t      root_chain [0:NR];
    lprip_pkg::side_t      side_chain [0:NR];
    logic                  rot_valid  [0:NC];
    lprip_pkg::rot_t       rot_chain  [0:NC];
    lprip_pkg::meta_t      meta_chain [0:NC];

    // Setup stage.
    logic                  setup_valid_reg;
    lprip_pkg::rot_t       rot_next;
    lprip_pkg::rot_t       rot_reg;
    lprip_pkg::meta_t      meta_next;
    lprip_pkg::meta_t      meta_reg;
    logic [lprip_pkg::RAD_W-1:0]  rng_full;
    logic [31:0]           hs;
    logic signed [DW:0]    az_u;
    logic signed [DW:0]    az_v;

    // The chain moves unless a finished result is held by the consumer.
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Origin registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lprip_pkg::REG_ORIGIN_X: origin_x_reg <= cfg_data;
                lprip_pkg::REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                lprip_pkg::REG_ORIGIN_Z: origin_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Translation and radicands. The sum of three squares stays below 2^50.
    always_comb
    begin
        diff_next.dx   = DW'(point_x) - DW'(origin_x_reg);
        diff_next.dy   = DW'(point_y) - DW'(origin_y_reg);
        diff_next.dz   = DW'(point_z) - DW'(origin_z_reg);
        diff_next.zero = (point_x == origin_x_reg) && (point_y == origin_y_reg)
                         && (point_z == origin_z_reg);
        hsq = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        rsq = hsq + {1'b0, sqz_reg};
        root_start.n_a = {rsq, 14'd0};
        root_start.r_a = '0;
        root_start.n_b = {hsq, 14'd0};
        root_start.r_b = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= '0;
        end
        else if (en)
        begin
            front_valid_reg <= {front_valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg       <= diff_next;
            sqx_reg        <= lprip_pkg::SQ_W'(diff_reg.dx * diff_reg.dx);
            sqy_reg        <= lprip_pkg::SQ_W'(diff_reg.dy * diff_reg.dy);
            sqz_reg        <= lprip_pkg::SQ_W'(diff_reg.dz * diff_reg.dz);
            sq_side_reg    <= diff_reg;
            root_start_reg <= root_start;
            side_start_reg <= sq_side_reg;
        end
    end

    assign root_valid[0] = front_valid_reg[2];
    assign root_chain[0] = root_start_reg;
    assign side_chain[0] = side_start_reg;

    // Square root chain.
    for (genvar i = 0; i < NR; i++)
    begin : g_root
        lprip_sqrt_cell #(
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (root_valid[i]),
            .root_in   (root_chain[i]),
            .side_in   (side_chain[i]),
            .valid_out (root_valid[i+1]),
            .root_out  (root_chain[i+1]),
            .side_out  (side_chain[i+1])
        );
    end

    // Setup of the azimuth and elevation vectors.
    always_comb
    begin
        rng_full = root_chain[NR].r_a >> 7;
        hs       = root_chain[NR].r_b[31:0];
        az_u     = -$signed({side_chain[NR].dy[DW-1], side_chain[NR].dy});
        az_v     = -$signed({side_chain[NR].dx[DW-1], side_chain[NR].dx});

        meta_next.zero = side_chain[NR].zero;
        meta_next.rng  = (rng_full > 64'(lprip_pkg::RANGE_MAX)) ? lprip_pkg::RANGE_MAX
                                                                : rng_full[24:0];

        rot_next.u_a   = CW'(az_u) <<< 30;
        rot_next.v_a   = CW'(az_v) <<< 30;
        rot_next.acc_a = '0;
        if (az_u == '0)
        begin
            rot_next.v_a = '0;
            if (az_v == '0)
            begin
                rot_next.acc_a = lprip_pkg::HALF_TURN;
            end
            else if (!az_v[DW])
            begin
                rot_next.acc_a = lprip_pkg::QUARTER_TURN;
            end
            else
            begin
                rot_next.acc_a = lprip_pkg::THREE_QUARTER_TURN;
            end
        end
        else if (az_u[DW])
        begin
            rot_next.u_a   = CW'(-az_u) <<< 30;
            rot_next.v_a   = CW'(-az_v) <<< 30;
            rot_next.acc_a = lprip_pkg::HALF_TURN;
        end

        rot_next.u_e   = CW'({1'b0, hs}) <<< 22;
        rot_next.v_e   = CW'(side_chain[NR].dz) <<< 29;
        rot_next.acc_e = '0;
        if (hs == '0)
        begin
            rot_next.v_e   = '0;
            rot_next.acc_e = (side_chain[NR].dz > 0) ? lprip_pkg::QUARTER_TURN
                                                     : lprip_pkg::THREE_QUARTER_TURN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            setup_valid_reg <= root_valid[NR];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg  <= rot_next;
            meta_reg <= meta_next;
        end
    end

    assign rot_valid[0]  = setup_valid_reg;
    assign rot_chain[0]  = rot_reg;
    assign meta_chain[0] = meta_reg;

    // Rotation chain.
    for (genvar i = 0; i < NC; i++)
    begin : g_rot
        lprip_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (rot_valid[i]),
            .rot_in    (rot_chain[i]),
            .meta_in   (meta_chain[i]),
            .valid_out (rot_valid[i+1]),
            .rot_out   (rot_chain[i+1]),
            .meta_out  (meta_chain[i+1])
        );
    end

    // Pixel mapping and output register.
    lprip_map #(
        .IMAGE_COLUMNS (IMAGE_COLUMNS),
        .IMAGE_ROWS    (IMAGE_ROWS)
    ) u_map (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .valid_in     (rot_valid[NC]),
        .yaw          (rot_chain[NC].acc_a),
        .elev         (rot_chain[NC].acc_e),
        .meta_in      (meta_chain[NC]),
        .valid_out    (out_valid),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .range_value  (range_value),
        .zero_range   (zero_range)
    );

    // A point at the origin gives all-zero fields.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_range |-> pixel_column == '0 && pixel_row == '0
                                    && range_value == '0)
        else $error("zero range result carries nonzero fields");

    // The range never exceeds its saturation limit.
    a_range_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> range_value <= lprip_pkg::RANGE_MAX)
        else $error("range above saturation limit");

    // Columns stay inside the image when the width fits the field.
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(pixel_column) < IMAGE_COLUMNS) || (IMAGE_COLUMNS > 2048))
        else $error("column outside image");

    // Rows stay at or below the image height when the height fits the field.
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(pixel_row) <= IMAGE_ROWS) || (IMAGE_ROWS >= 2048))
        else $error("row outside image");

endmodule
